// File: hdl/dfs_path_finder_core_defines.svh
// Assertion macros used by the path finder datapath.
`ifndef DFS_PATH_FINDER_CORE_DEFINES_SVH
`define DFS_PATH_FINDER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DPF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define DPF_ASSERT_IMPLIES(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) else $error(msg);

`endif

// File: hdl/dpf_pkg.sv
// Shared types, sizes and codes of the depth-first path finder.
package dpf_pkg;

	localparam int MAX_NODES  = 64;
	localparam int MAX_DEGREE = 16;

	localparam int FIELD_W = 6;
	localparam int CFG_W   = 7;
	localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W   = $clog2(MAX_NODES + 1);
	localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
	localparam int NB_DEPTH = MAX_NODES * MAX_DEGREE;
	localparam int NB_AW   = (NB_DEPTH > 1) ? $clog2(NB_DEPTH) : 1;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DEG_W-1:0]  deg_t;
	typedef logic [NB_AW-1:0]  nb_addr_t;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_SEARCH = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOPATH  = 2'd1,
		ST_BADNODE = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_DEG_B,
		S_DEG_CHK,
		S_ADD_B,
		S_POP,
		S_POP_WAIT,
		S_DEG_WAIT,
		S_SCAN,
		S_NB_WAIT,
		S_FIN,
		S_WALK,
		S_WALK_WAIT,
		S_EMIT,
		S_EMIT_WAIT,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    cap;
		logic    clr_deg;
		logic    set_res;
		status_t res_code;
		logic    ld_res;
		logic    rd_dega;
		logic    lat_dega;
		logic    add_a;
		logic    add_b;
		logic    srch_init;
		logic    pop;
		logic    pop_lat;
		logic    deg_lat;
		logic    scan_rd;
		logic    nb_chk;
		logic    walk_init;
		logic    walk_wr;
		logic    walk_lat;
		logic    emit_rd;
		logic    emit_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  bad;
		logic  full;
		logic  sp_zero;
		logic  scan_done;
		logic  end_vis;
		logic  walk_last;
		logic  len_one;
		logic  out_free;
	} dp_sts_t;

	function automatic nb_addr_t nb_addr(node_t node, deg_t idx);
		return NB_AW'(NB_AW'(node) * NB_AW'(MAX_DEGREE) + NB_AW'(idx));
	endfunction

endpackage

// File: hdl/dpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/dpf_ctrl.sv
// Controller state machine of the path finder.
module dpf_ctrl
	import dpf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_nx = S_DISPATCH;
			S_DISPATCH: begin
				case (sts.func)
					FN_ADD:    state_nx = sts.bad ? S_RESULT : S_DEG_B;
					FN_SEARCH: state_nx = sts.bad ? S_RESULT : S_POP;
					FN_CLEAR:  state_nx = S_RESULT;
					default:   state_nx = S_IDLE;
				endcase
			end
			S_DEG_B:     state_nx = S_DEG_CHK;
			S_DEG_CHK:   state_nx = sts.full ? S_RESULT : S_ADD_B;
			S_ADD_B:     state_nx = S_RESULT;
			S_POP:       state_nx = sts.sp_zero ? S_FIN : S_POP_WAIT;
			S_POP_WAIT:  state_nx = S_DEG_WAIT;
			S_DEG_WAIT:  state_nx = S_SCAN;
			S_SCAN:      state_nx = sts.scan_done ? S_POP : S_NB_WAIT;
			S_NB_WAIT:   state_nx = S_SCAN;
			S_FIN:       state_nx = sts.end_vis ? S_WALK : S_RESULT;
			S_WALK:      state_nx = sts.walk_last ? S_EMIT : S_WALK_WAIT;
			S_WALK_WAIT: state_nx = S_WALK;
			S_EMIT:      state_nx = S_EMIT_WAIT;
			S_EMIT_WAIT: begin
				if (sts.out_free) state_nx = sts.len_one ? S_IDLE : S_EMIT;
			end
			S_RESULT:    if (sts.out_free) state_nx = S_IDLE;
			default:     state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_code = ST_OK;
		case (state_q)
			S_IDLE:      cmd.cap = in_valid;
			S_DISPATCH: begin
				case (sts.func)
					FN_ADD: begin
						if (sts.bad) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_BADNODE;
						end else begin
							cmd.rd_dega = 1'b1;
						end
					end
					FN_SEARCH: begin
						if (sts.bad) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = ST_BADNODE;
						end else begin
							cmd.srch_init = 1'b1;
						end
					end
					FN_CLEAR: begin
						cmd.clr_deg  = 1'b1;
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_OK;
					end
					default: cmd.cap = 1'b0;
				endcase
			end
			S_DEG_B:     cmd.lat_dega = 1'b1;
			S_DEG_CHK: begin
				if (sts.full) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_FULL;
				end else begin
					cmd.add_a = 1'b1;
				end
			end
			S_ADD_B: begin
				cmd.add_b    = 1'b1;
				cmd.set_res  = 1'b1;
				cmd.res_code = ST_OK;
			end
			S_POP:       cmd.pop = !sts.sp_zero;
			S_POP_WAIT:  cmd.pop_lat = 1'b1;
			S_DEG_WAIT:  cmd.deg_lat = 1'b1;
			S_SCAN:      cmd.scan_rd = !sts.scan_done;
			S_NB_WAIT:   cmd.nb_chk = 1'b1;
			S_FIN: begin
				if (sts.end_vis) begin
					cmd.walk_init = 1'b1;
				end else begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NOPATH;
				end
			end
			S_WALK:      cmd.walk_wr = 1'b1;
			S_WALK_WAIT: cmd.walk_lat = 1'b1;
			S_EMIT:      cmd.emit_rd = 1'b1;
			S_EMIT_WAIT: cmd.emit_out = sts.out_free;
			S_RESULT:    cmd.ld_res = sts.out_free;
			default:     cmd.cap = 1'b0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// File: hdl/dpf_dp.sv
// Datapath of the path finder: graph store, search scratch and output register.
`include "dfs_path_finder_core_defines.svh"
module dpf_dp
	import dpf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic [1:0]         func,
	input  logic [FIELD_W-1:0] node_a,
	input  logic [FIELD_W-1:0] node_b,
	input  ctl_cmd_t           cmd,
	output dp_sts_t            sts,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] path_node,
	output logic [1:0]         status,
	output logic               last
);

	logic [CFG_W-1:0]   cfg_q;
	cnt_t               n_act;
	logic [1:0]         func_q;
	logic [FIELD_W-1:0] a_q, b_q;
	node_t              a_i, b_i;
	status_t            res_q;
	deg_t               deg_a_q, deg_b_q, deg_cur_q, idx_q;
	deg_t               deg_b_now, deg_cur_now;
	logic [DEG_W:0]     deg_a_two;
	cnt_t               sp_q, len_q;
	node_t              cur_q;
	logic [MAX_NODES-1:0] dvalid_q, visited_q;
	logic               out_valid_q, last_q;
	logic [FIELD_W-1:0] path_node_q;
	status_t            status_q;
	logic               out_free;

	// RAM ports
	logic     deg_we, deg_re;
	node_t    deg_waddr, deg_raddr;
	deg_t     deg_wdata, deg_rdata;
	logic     nb_we;
	nb_addr_t nb_waddr;
	node_t    nb_wdata, nb_rdata;
	logic     st_we, st_re;
	node_t    st_waddr, st_wdata, st_raddr, st_rdata;
	logic     nb_new;
	node_t    par_rdata, path_rdata;

	assign n_act = (cfg_q == '0) ? cnt_t'(1) :
		(cfg_q > CFG_W'(MAX_NODES)) ? cnt_t'(MAX_NODES) : cnt_t'(cfg_q);
	assign a_i = a_q[NODE_W-1:0];
	assign b_i = b_q[NODE_W-1:0];

	assign deg_b_now   = dvalid_q[b_i] ? deg_rdata : '0;
	assign deg_cur_now = !dvalid_q[cur_q] ? '0 :
		(deg_rdata > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_rdata;
	assign deg_a_two   = {1'b0, deg_a_q} + (DEG_W+1)'(2);
	assign nb_new      = ((CNT_W+1)'(nb_rdata) < (CNT_W+1)'(n_act)) && !visited_q[nb_rdata];
	assign out_free    = !out_valid_q || !out_stall;

	// Degree store: one entry per node, valid bits stand in for the reset value
	assign deg_we    = cmd.add_a || cmd.add_b;
	assign deg_waddr = cmd.add_a ? a_i : b_i;
	assign deg_wdata = cmd.add_a ? DEG_W'(deg_a_q + 1'b1) : DEG_W'(deg_b_q + 1'b1);
	assign deg_re    = cmd.rd_dega || cmd.lat_dega || cmd.pop_lat;
	always_comb begin
		deg_raddr = a_i;
		if (cmd.lat_dega) deg_raddr = b_i;
		if (cmd.pop_lat)  deg_raddr = st_rdata;
	end

	dpf_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata)
	);

	// Neighbour lists
	assign nb_we    = cmd.add_a || cmd.add_b;
	assign nb_waddr = cmd.add_a ? nb_addr(a_i, deg_a_q) : nb_addr(b_i, deg_b_q);
	assign nb_wdata = cmd.add_a ? b_i : a_i;

	dpf_ram #(.WIDTH(NODE_W), .DEPTH(NB_DEPTH)) u_nb_ram (
		.clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
		.re(cmd.scan_rd), .raddr(nb_addr(cur_q, idx_q)), .rdata(nb_rdata)
	);

	// Search stack
	assign st_we    = cmd.srch_init || (cmd.nb_chk && nb_new && (sp_q < cnt_t'(MAX_NODES)));
	assign st_waddr = cmd.srch_init ? '0 : sp_q[NODE_W-1:0];
	assign st_wdata = cmd.srch_init ? a_i : nb_rdata;
	assign st_re    = cmd.pop;
	assign st_raddr = NODE_W'(sp_q - 1'b1);

	dpf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_stack_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.re(st_re), .raddr(st_raddr), .rdata(st_rdata)
	);

	// Parent of each node, written when the node is marked
	dpf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
		.clk(clk), .we(cmd.nb_chk && nb_new), .waddr(nb_rdata), .wdata(cur_q),
		.re(cmd.walk_wr), .raddr(cur_q), .rdata(par_rdata)
	);

	// Path, stored from end back to start
	dpf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_path_ram (
		.clk(clk), .we(cmd.walk_wr), .waddr(len_q[NODE_W-1:0]), .wdata(cur_q),
		.re(cmd.emit_rd), .raddr(NODE_W'(len_q - 1'b1)), .rdata(path_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_W'(MAX_NODES);
			dvalid_q    <= '0;
			visited_q   <= '0;
			sp_q        <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) cfg_q <= cfg_wdata;
			if (cmd.clr_deg) dvalid_q <= '0;
			if (cmd.add_a) dvalid_q[a_i] <= 1'b1;
			if (cmd.add_b) dvalid_q[b_i] <= 1'b1;
			if (cmd.srch_init) begin
				visited_q <= {{(MAX_NODES-1){1'b0}}, 1'b1} << a_i;
				sp_q      <= cnt_t'(1);
			end
			if (cmd.pop) sp_q <= sp_q - 1'b1;
			if (cmd.nb_chk && nb_new) begin
				visited_q[nb_rdata] <= 1'b1;
				if (sp_q < cnt_t'(MAX_NODES)) sp_q <= sp_q + 1'b1;
			end
			if (cmd.walk_init) len_q <= '0;
			if (cmd.walk_wr)   len_q <= len_q + 1'b1;
			if (cmd.emit_out)  len_q <= len_q - 1'b1;
			if (cmd.ld_res || cmd.emit_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= func;
			a_q    <= node_a;
			b_q    <= node_b;
		end
		if (cmd.set_res)  res_q <= cmd.res_code;
		if (cmd.lat_dega) deg_a_q <= dvalid_q[a_i] ? deg_rdata : '0;
		if (cmd.add_a)    deg_b_q <= (a_i == b_i) ? DEG_W'(deg_a_q + 1'b1) : deg_b_now;
		if (cmd.pop_lat)  cur_q <= st_rdata;
		if (cmd.walk_init) cur_q <= b_i;
		if (cmd.walk_lat) cur_q <= par_rdata;
		if (cmd.deg_lat) begin
			deg_cur_q <= deg_cur_now;
			idx_q     <= '0;
		end
		if (cmd.scan_rd) idx_q <= idx_q + 1'b1;
		if (cmd.ld_res) begin
			path_node_q <= '0;
			status_q    <= res_q;
			last_q      <= 1'b1;
		end
		if (cmd.emit_out) begin
			path_node_q <= FIELD_W'(path_rdata);
			status_q    <= ST_OK;
			last_q      <= (len_q == cnt_t'(1));
		end
	end

	always_comb begin
		sts.func      = func_t'(func_q);
		sts.bad       = ({1'b0, a_q} >= (FIELD_W+1)'(n_act)) ||
			({1'b0, b_q} >= (FIELD_W+1)'(n_act));
		sts.full      = (a_i == b_i) ? (deg_a_two > (DEG_W+1)'(MAX_DEGREE)) :
			((deg_a_q >= DEG_W'(MAX_DEGREE)) || (deg_b_now >= DEG_W'(MAX_DEGREE)));
		sts.sp_zero   = (sp_q == '0);
		sts.scan_done = (idx_q >= deg_cur_q);
		sts.end_vis   = visited_q[b_i];
		sts.walk_last = (cur_q == a_i) || ((len_q + 1'b1) >= n_act);
		sts.len_one   = (len_q == cnt_t'(1));
		sts.out_free  = out_free;
	end

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign status    = status_q;
	assign last      = last_q;

	`DPF_ASSERT_ALWAYS(a_sp_bound, sp_q <= cnt_t'(MAX_NODES), "stack pointer past depth")
	`DPF_ASSERT_IMPLIES(a_deg_bound, deg_we, deg_wdata <= DEG_W'(MAX_DEGREE), "degree overflow")
	`DPF_ASSERT_ALWAYS(a_one_load, !(cmd.ld_res && cmd.emit_out), "two result loads")
	`DPF_ASSERT_IMPLIES(a_load_free, cmd.ld_res || cmd.emit_out, out_free, "result overwritten")

endmodule

// File: hdl/dfs_path_finder_core.sv
// Top level of the depth-first path finder: controller plus datapath.
// Keeps an undirected graph of up to 64 nodes as neighbour lists (16 entries per node) and
// answers three requests: add edge (one result: ok, bad node or list full), clear graph (one
// result: ok) and search (the path from start to end, one node per result with last on the
// final one, or a single no-path or bad-node result). A func code of 3 is dropped without a
// result. Requests are taken one at a time; in_stall is high from acceptance until the
// block is back in idle. An add edge passes through dispatch, the degree reads of both ends,
// the full check, one list write per end and the result state; a clear goes from dispatch
// straight to the result state; both then wait for the output register to free up. A search
// pops a node, reads its degree and scans its neighbour list with one neighbour RAM read per
// entry, marking and pushing each new neighbour; it then walks parents back from the end and
// emits each path node as the output register frees up. A finished result sits in the
// output register while the next request is accepted. node_count must be written only while
// the block is idle (not enforced here); 0 acts as 1 and values above 64 act as 64.
module dfs_path_finder_core
	import dpf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [FIELD_W-1:0] node_a,
	input  logic [FIELD_W-1:0] node_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] path_node,
	output logic [1:0]         status,
	output logic               last
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// Sequence each request through the datapath
	dpf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	// Hold the graph, run the search and drive the result register
	dpf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.func(func), .node_a(node_a), .node_b(node_b), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .path_node(path_node),
		.status(status), .last(last)
	);

endmodule

// File: sim/dfs_path_finder_core_test.sv
// Testbench for dfs_path_finder_core: directed and random requests checked against a predictor.
module dfs_path_finder_core_test;
	import dpf_pkg::*;

	typedef struct packed {
		logic [5:0] node;
		status_t    code;
		logic       fin;
	} route_step_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 40;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic [FIELD_W-1:0] node_a;
	logic [FIELD_W-1:0] node_b;
	logic               out_valid;
	logic               out_stall;
	logic [FIELD_W-1:0] path_node;
	logic [1:0]         status;
	logic               last;

	// Predictor state: neighbour lists, degrees and the node count in force.
	node_t       graph_nbr [MAX_NODES][MAX_DEGREE];
	int unsigned graph_deg [MAX_NODES];
	int unsigned node_cnt_reg;

	route_step_t expected_steps[$];
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned results_seen;
	int unsigned idle_cycles;
	bit          hold_off_req;

	dfs_path_finder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.path_node (path_node),
		.status    (status),
		.last      (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int unsigned active_nodes();
		if (node_cnt_reg < 1) return 1;
		if (node_cnt_reg > MAX_NODES) return MAX_NODES;
		return node_cnt_reg;
	endfunction

	function automatic void push_step(logic [5:0] nd, status_t code, logic fin);
		route_step_t s;
		s.node = nd;
		s.code = code;
		s.fin  = fin;
		expected_steps = {expected_steps, s};
	endfunction

	// Append each endpoint to the other's list; drop the whole edge when a list is full.
	function automatic void predict_edge(int unsigned a, int unsigned b);
		int unsigned n;
		n = active_nodes();
		if (a >= n || b >= n) begin
			push_step(6'd0, ST_BADNODE, 1'b1);
			return;
		end
		if ((a == b && graph_deg[a] + 2 > MAX_DEGREE) ||
		    (a != b && (graph_deg[a] >= MAX_DEGREE || graph_deg[b] >= MAX_DEGREE))) begin
			push_step(6'd0, ST_FULL, 1'b1);
			return;
		end
		graph_nbr[a][graph_deg[a]] = node_t'(b);
		graph_deg[a]++;
		graph_nbr[b][graph_deg[b]] = node_t'(a);
		graph_deg[b]++;
		push_step(6'd0, ST_OK, 1'b1);
	endfunction

	// Stack-based depth-first search; mark and set parent on push, then walk parents back.
	function automatic void predict_route(int unsigned s, int unsigned e);
		int unsigned n;
		int unsigned sp;
		int unsigned cur;
		int unsigned nb;
		int unsigned len;
		bit          seen [MAX_NODES];
		int unsigned parent [MAX_NODES];
		int unsigned stack [MAX_NODES];
		int unsigned path [MAX_NODES];
		n = active_nodes();
		if (s >= n || e >= n) begin
			push_step(6'd0, ST_BADNODE, 1'b1);
			return;
		end
		foreach (seen[i]) begin
			seen[i] = 1'b0;
			parent[i] = 0;
		end
		seen[s] = 1'b1;
		stack[0] = s;
		sp = 1;
		while (sp > 0) begin
			sp--;
			cur = stack[sp];
			for (int unsigned i = 0; i < graph_deg[cur]; i++) begin
				nb = graph_nbr[cur][i];
				if (nb >= n || seen[nb]) continue;
				seen[nb] = 1'b1;
				parent[nb] = cur;
				if (sp < MAX_NODES) begin
					stack[sp] = nb;
					sp++;
				end
			end
		end
		if (!seen[e]) begin
			push_step(6'd0, ST_NOPATH, 1'b1);
			return;
		end
		cur = e;
		len = 0;
		while (len < n) begin
			path[len] = cur;
			len++;
			if (cur == s) break;
			cur = parent[cur];
		end
		for (int unsigned i = len; i > 0; i--)
			push_step(6'(path[i-1]), ST_OK, i == 1);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request, hold it until accepted, then predict its results.
	task automatic send_request(func_t f, int unsigned a, int unsigned b);
		int unsigned gap;
		in_valid <= 1'b1;
		func     <= f;
		node_a   <= FIELD_W'(a);
		node_b   <= FIELD_W'(b);
		do @(posedge clk); while (in_stall);
		requests_sent++;
		case (f)
			FN_ADD:    predict_edge(a, b);
			FN_SEARCH: predict_route(a, b);
			FN_CLEAR: begin
				foreach (graph_deg[i]) graph_deg[i] = 0;
				push_step(6'd0, ST_OK, 1'b1);
			end
			default: ;
		endcase
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain outstanding results, let a possibly dropped request finish, then write the register.
	task automatic write_node_count(int unsigned v);
		in_valid <= 1'b0;
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_wen <= 1'b0;
		node_cnt_reg = v;
	endtask

	task automatic test_directed();
		send_request(FN_CLEAR, 0, 0);
		send_request(FN_ADD, 0, 63);
		send_request(FN_ADD, 63, 63);
		send_request(FN_ADD, 0, 63);
		send_request(FN_SEARCH, 0, 63);
		send_request(FN_SEARCH, 63, 0);
		send_request(FN_SEARCH, 5, 5);
		send_request(FN_SEARCH, 0, 7);
		send_request(FN_NONE, 42, 21);
		// Fill node 1's list, overflow it, then add a self-loop, which takes two slots.
		for (int unsigned k = 2; k < 17; k++)
			send_request(FN_ADD, 1, k);
		send_request(FN_ADD, 1, 63);
		send_request(FN_ADD, 1, 20);
		send_request(FN_ADD, 2, 2);
		send_request(FN_SEARCH, 16, 2);
	endtask

	task automatic test_node_count();
		write_node_count(0);
		send_request(FN_ADD, 0, 0);
		send_request(FN_ADD, 0, 1);
		send_request(FN_SEARCH, 0, 0);
		send_request(FN_SEARCH, 1, 0);
		write_node_count(10);
		// Node 0 still lists 63: skip it as a stale neighbour.
		send_request(FN_ADD, 0, 9);
		send_request(FN_ADD, 9, 10);
		send_request(FN_SEARCH, 0, 9);
		send_request(FN_SEARCH, 3, 9);
		write_node_count(127);
		send_request(FN_SEARCH, 0, 63);
		send_request(FN_ADD, 62, 63);
		send_request(FN_SEARCH, 62, 0);
		write_node_count(64);
	endtask

	task automatic test_backpressure();
		send_request(FN_CLEAR, 0, 0);
		for (int unsigned k = 0; k < 40; k++)
			send_request(FN_ADD, k, k + 1);
		hold_off_req = 1'b1;
		send_request(FN_SEARCH, 0, 40);
		send_request(FN_SEARCH, 40, 3);
		send_request(FN_ADD, 41, 42);
		send_request(FN_SEARCH, 7, 7);
	endtask

	// Mostly in-range edges and searches on a random graph; a few clears, bad nodes and func 3.
	task automatic test_random_phase(int unsigned ncfg, int unsigned count);
		int unsigned n;
		int unsigned r;
		int unsigned a;
		int unsigned b;
		write_node_count(ncfg);
		n = active_nodes();
		send_request(FN_CLEAR, 0, 0);
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
			if ($urandom_range(0, 99) < 8) a = $urandom_range(0, 63);
			if ($urandom_range(0, 99) < 8) b = $urandom_range(0, 63);
			if (r < 55)      send_request(FN_ADD, a, b);
			else if (r < 93) send_request(FN_SEARCH, a, b);
			else if (r < 97) send_request(FN_CLEAR, a, b);
			else             send_request(FN_NONE, a, b);
		end
	endtask

	// Receiver: random stall runs, plus one long hold-off on request.
	initial begin
		int unsigned len;
		out_stall <= 1'b0;
		forever begin
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                  : $urandom_range(1, 4);
				repeat (len) @(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		route_step_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_steps.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result node=%0d status=%0d last=%0d",
				         $time, path_node, status, last);
			end else begin
				want = expected_steps.pop_front();
				if (path_node !== want.node) begin
					mismatches++;
					$display("%0t: path_node expected %0d actual %0d",
					         $time, want.node, path_node);
				end
				if (status !== want.code) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d",
					         $time, want.code, status);
				end
				if (last !== want.fin) begin
					mismatches++;
					$display("%0t: last expected %0d actual %0d",
					         $time, want.fin, last);
				end
			end
		end
	end

	// Watchdog: count cycles with no request or result moving.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding",
			         $time, expected_steps.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		mismatches    = 0;
		requests_sent = 0;
		results_seen  = 0;
		idle_cycles   = 0;
		hold_off_req  = 1'b0;
		node_cnt_reg  = 64;
		foreach (graph_deg[i]) graph_deg[i] = 0;
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		func      <= '0;
		node_a    <= '0;
		node_b    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_node_count();
		test_backpressure();
		test_random_phase(6, 38);
		test_random_phase(20, 42);
		test_random_phase(64, 42);
		test_random_phase(100, 38);
		test_random_phase(2, 15);

		in_valid <= 1'b0;
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests and %0d results: edges, clears, searches, bad nodes,",
		         requests_sent, results_seen);
		$display("full lists, stale neighbours, node counts 0..127 and a long output hold-off.");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/dpf_pkg.sv
hdl/dpf_ram.sv
hdl/dpf_ctrl.sv
hdl/dpf_dp.sv
hdl/dfs_path_finder_core.sv
sim/dfs_path_finder_core_test.sv
